/* rtl/core/mrr_pkg.sv */
// ----------------------------------------------------------------------------
// mrr_pkg: shared types for the Miller-Rabin round
// Field width and the field type used by the channels.
// ----------------------------------------------------------------------------
`default_nettype none
package mrr_pkg;
    localparam int unsigned FIELD_W = 32;
    typedef logic [FIELD_W-1:0] t_field;
endpackage
`default_nettype wire

/* rtl/core/mrr_in_if.sv */
// ----------------------------------------------------------------------------
// mrr_in_if: input channel
// Candidate and witness with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface mrr_in_if;
    logic            valid;
    logic            ready;
    mrr_pkg::t_field candidate;
    mrr_pkg::t_field witness;
    modport source (output valid, output candidate, output witness, input ready);
    modport sink   (input valid, input candidate, input witness, output ready);
endinterface
`default_nettype wire

/* rtl/core/mrr_out_if.sv */
// ----------------------------------------------------------------------------
// mrr_out_if: result channel
// One verdict bit with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface mrr_out_if;
    logic valid;
    logic ready;
    logic verdict;
    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface
`default_nettype wire

/* rtl/core/mrr_front.sv */
// ----------------------------------------------------------------------------
// mrr_front: classifier
// Decides trivial candidates at once; others go on as jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module mrr_front #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    mrr_in_if.sink                in_ch,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_decided,
    output logic                  o_verdict,
    output logic [WIDTH-1:0]      o_n,
    output logic [WIDTH-1:0]      o_a
);
    logic [WIDTH-1:0] w_n;
    logic             r_valid;
    logic             n_dec, n_ver;

    assign w_n = WIDTH'(in_ch.candidate);
    assign in_ch.ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_comb begin
        n_dec = 1'b1;
        n_ver = 1'b0;
        if (w_n == WIDTH'(2) || w_n == WIDTH'(3)) begin
            n_ver = 1'b1;
        end else if (w_n <= WIDTH'(1) || !w_n[0]) begin
            n_ver = 1'b0;
        end else begin
            n_dec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ch.valid && in_ch.ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (in_ch.valid && in_ch.ready) begin
            o_decided <= n_dec;
            o_verdict <= n_ver;
            o_n       <= w_n;
            o_a       <= WIDTH'(in_ch.witness);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/mrr_back.sv */
// ----------------------------------------------------------------------------
// mrr_back: modular exponent engine
// One shift-add step per cycle for a mod n, a^d mod n and the squarings.
// ----------------------------------------------------------------------------
`default_nettype none
module mrr_back #(
    parameter int WIDTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic         i_decided,
    input  wire logic         i_verdict,
    input  wire logic [WIDTH-1:0] i_n,
    input  wire logic [WIDTH-1:0] i_a,
    mrr_out_if.source         out_ch
);
    localparam int CW = $clog2(WIDTH + 1);
    localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_SPLIT = 3'd2,
                           S_MUL = 3'd3, S_POWCHK = 3'd4, S_SQ = 3'd5,
                           S_DONE = 3'd6;

    logic [2:0]       r_st;
    logic [WIDTH-1:0] r_n, r_nm1, r_d, r_e, r_base, r_res, r_acc, r_x, r_y;
    logic [CW-1:0]    r_s, r_i, r_bit;
    logic             r_mtgt;   // 0: res*base 1: base*base
    logic             r_sqph;   // multiply belongs to squaring phase
    logic             r_ov;

    // acc = 2acc (+x) mod n, two add_mod steps
    logic [WIDTH:0]   w_dbl, w_add;
    logic [WIDTH-1:0] w_a1, w_a2;
    always_comb begin
        w_dbl = {1'b0, r_acc} + {1'b0, r_acc};
        w_a1  = (w_dbl >= {1'b0, r_n}) ? WIDTH'(w_dbl - {1'b0, r_n}) : w_dbl[WIDTH-1:0];
        w_add = {1'b0, w_a1} + {1'b0, r_x};
        w_a2  = w_a1;
        if (r_y[r_bit[$clog2(WIDTH)-1:0]])
            w_a2 = (w_add >= {1'b0, r_n}) ? WIDTH'(w_add - {1'b0, r_n})
                                         : w_add[WIDTH-1:0];
    end

    // restoring reduction of a mod n: rem = 2rem+bit
    logic [WIDTH:0]   w_rs;
    always_comb begin
        w_rs = {r_acc, r_base[WIDTH-1 - r_bit[$clog2(WIDTH)-1:0]]};
    end

    assign o_ready = (r_st == S_IDLE);
    assign out_ch.valid = (r_st == S_DONE);
    assign out_ch.verdict = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_n <= i_n; r_nm1 <= i_n - WIDTH'(1);
                    r_d <= i_n - WIDTH'(1); r_s <= '0;
                    r_base <= i_a; r_acc <= '0; r_bit <= '0;
                    if (i_decided) begin
                        r_ov <= i_verdict; r_st <= S_DONE;
                    end else begin
                        r_st <= S_RED;
                    end
                end
                S_RED: begin
                    r_acc <= (w_rs >= {1'b0, r_n}) ? WIDTH'(w_rs - {1'b0, r_n})
                                                 : w_rs[WIDTH-1:0];
                    r_bit <= r_bit + CW'(1);
                    if (r_bit == CW'(WIDTH - 1)) r_st <= S_SPLIT;
                end
                S_SPLIT: begin
                    if (r_bit == CW'(WIDTH)) begin
                        r_base <= r_acc; r_bit <= '0;
                        if (r_acc == '0) begin
                            r_ov <= 1'b1; r_st <= S_DONE;
                        end
                    end else if (!r_d[0]) begin
                        r_d <= r_d >> 1; r_s <= r_s + CW'(1);
                    end else begin
                        r_e <= r_d; r_res <= WIDTH'(1); r_sqph <= 1'b0;
                        r_st <= S_POWCHK;
                    end
                end
                S_POWCHK: begin
                    // drive next multiply of exponentiation, or check the result once e is spent
                    if (r_e == '0) begin
                        r_x <= r_res; r_i <= CW'(1);
                        if (r_res == WIDTH'(1) || r_res == r_nm1) begin
                            r_ov <= 1'b1; r_st <= S_DONE;
                        end else begin
                            r_st <= S_SQ;
                        end
                    end else begin
                        r_mtgt <= ~r_e[0];
                        r_x <= r_e[0] ? r_res : r_base;
                        r_y <= r_base;
                        r_acc <= '0; r_bit <= CW'(WIDTH - 1);
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc <= w_a2;
                    if (r_bit == '0) begin
                        if (r_sqph) begin
                            r_x <= w_a2; r_i <= r_i + CW'(1);
                            if (w_a2 == r_nm1) begin
                                r_ov <= 1'b1; r_st <= S_DONE;
                            end else if (w_a2 == WIDTH'(1)) begin
                                r_ov <= 1'b0; r_st <= S_DONE;
                            end else begin
                                r_st <= S_SQ;
                            end
                        end else if (!r_mtgt) begin
                            r_res <= w_a2; r_mtgt <= 1'b1;
                            r_x <= r_base; r_y <= r_base;
                            r_acc <= '0; r_bit <= CW'(WIDTH - 1);
                        end else begin
                            r_base <= w_a2; r_e <= r_e >> 1;
                            r_st <= S_POWCHK;
                        end
                    end else begin
                        r_bit <= r_bit - CW'(1);
                    end
                end
                S_SQ: begin
                    if (r_i >= r_s) begin
                        r_ov <= 1'b0; r_st <= S_DONE;
                    end else begin
                        r_sqph <= 1'b1; r_y <= r_x;
                        r_acc <= '0; r_bit <= CW'(WIDTH - 1);
                        r_st <= S_MUL;
                    end
                end
                S_DONE: if (out_ch.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/core/miller_rabin_round.sv */
// ----------------------------------------------------------------------------
// miller_rabin_round: one Miller-Rabin round per item
// Front classifies, back runs the modular exponentiation.
// ----------------------------------------------------------------------------
// Trivial candidates are decided in the front and go straight to the back's
// done state; others pass the witness reduction, the split of n-1 into d and
// s, then up to about 2*WIDTH modular multiplies for the exponent bits and the
// squarings, each run by the one-bit-per-cycle shift-add multiplier.
// Throughput: one item at a time in the back end; front holds one more.
// Reset: synchronous active-low i_rst_n clears the front's valid flag and the back's state.
`default_nettype none
module miller_rabin_round #(
    parameter int WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mrr_in_if.sink    in_ch,
    mrr_out_if.source out_ch
);
    logic             w_fv, w_br, w_dec, w_ver;
    logic [WIDTH-1:0] w_n, w_a;

    mrr_front #(.WIDTH(WIDTH)) u_front (
        .i_clk, .i_rst_n, .in_ch,
        .o_valid(w_fv), .i_ready(w_br), .o_decided(w_dec),
        .o_verdict(w_ver), .o_n(w_n), .o_a(w_a)
    );

    mrr_back #(.WIDTH(WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_br),
        .i_decided(w_dec), .i_verdict(w_ver), .i_n(w_n), .i_a(w_a), .out_ch
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.verdict))
        else $error("verdict dropped while stalled");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fv && w_br |=> out_ch.valid == $past(w_dec))
        else $error("result before work");
endmodule
`default_nettype wire

/* tb/mrr_checker.sv */
// ----------------------------------------------------------------------------
// mrr_checker: verdict predictor and scoreboard
// Watches both channels, predicts one Miller-Rabin verdict per accepted
// item and compares it with the verdicts the block returns, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module mrr_checker #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_candidate,
    input  logic [31:0] i_witness,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_verdict,
    output int          o_errors,
    output int          o_pending,
    output int          o_verdicts
);
    bit verdict_q[$];

    function automatic logic [64:0] mod_add(logic [64:0] x, logic [64:0] y, logic [64:0] m);
        logic [64:0] sum;
        sum = x + y;
        return (sum >= m) ? sum - m : sum;
    endfunction

    function automatic logic [64:0] mod_mul(logic [64:0] x, logic [64:0] y, logic [64:0] m);
        logic [64:0] acc;
        acc = 0;
        for (int b = WIDTH - 1; b >= 0; b--) begin
            acc = mod_add(acc, acc, m);
            if (y[b]) acc = mod_add(acc, x, m);
        end
        return acc;
    endfunction

    function automatic bit mr_verdict(logic [63:0] n_in, logic [63:0] a_in);
        logic [64:0] n, a, d, x, base, e;
        int s;
        n = n_in;
        a = a_in;
        if (n <= 1 || n == 4) return 0;
        if (n == 2 || n == 3) return 1;
        if (!n[0]) return 0;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        a = a % n;
        if (a == 0) return 1;
        x = 1;
        base = a;
        e = d;
        while (e != 0) begin
            if (e[0]) x = mod_mul(x, base, n);
            e = e >> 1;
            base = mod_mul(base, base, n);
        end
        if (x == 1 || x == n - 1) return 1;
        for (int i = 1; i < s; i++) begin
            x = mod_mul(x, x, n);
            if (x == n - 1) return 1;
            if (x == 1) return 0;
        end
        return 0;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_verdicts = 0;
    end

    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        logic [63:0] msk;
        bit want;
        msk = {64{1'b1}} >> (64 - WIDTH);
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                verdict_q.push_back(mr_verdict({32'b0, i_candidate} & msk,
                                               {32'b0, i_witness} & msk));
            if (i_out_valid && i_out_ready) begin
                o_verdicts++;
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict with none expected");
                end else begin
                    want = verdict_q.pop_front();
                    if (i_verdict !== want)
                        report_mismatch($sformatf("verdict %b, expected %b", i_verdict, want));
                end
            end
        end
    end
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: Miller-Rabin round testbench
// Drives directed and random candidate/witness pairs under several idle and
// stall patterns, including a long output stall; the checker scores verdicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending, verdicts;
    int   send_idle = 0, recv_stall = 0;
    bit   hold_off = 0;
    int   sent = 0;

    mrr_in_if  in_ch();
    mrr_out_if out_ch();

    miller_rabin_round #(.WIDTH(32)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    mrr_checker #(.WIDTH(32)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
        .i_candidate(in_ch.candidate), .i_witness(in_ch.witness),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .i_verdict(out_ch.verdict),
        .o_errors(errors), .o_pending(pending), .o_verdicts(verdicts)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.candidate = 0;
        in_ch.witness = 0;
        out_ch.ready = 0;
    end

    // receiver: random stall, or a long counted hold-off
    always @(negedge i_clk) begin
        if (hold_off) out_ch.ready <= 0;
        else out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    // valid stays up after the accept; the next call or the caller drops it
    task automatic send_item(logic [31:0] n, logic [31:0] a);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.candidate <= n;
        in_ch.witness <= a;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_odd();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom_range(255);
            1: v = $urandom_range(65535);
            default: v = $urandom;
        endcase
        return v | 32'd1;
    endfunction

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // known primes and composite pseudoprimes (strong or Carmichael) to exercise both verdicts
    logic [31:0] primes[6] = '{32'd4294967291, 32'd65537, 32'd2147483647, 32'd97,
                               32'd7919, 32'd3};
    logic [31:0] spsp[4] = '{32'd2047, 32'd3215031751, 32'd561, 32'd1373653};

    initial begin
        logic [31:0] n, a;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed
        send_item(0, 5);
        send_item(1, 0);
        send_item(2, 32'hFFFFFFFF);
        send_item(3, 7);
        send_item(4, 3);
        send_item(6, 5);
        send_item(32'hFFFFFFFE, 3);
        send_item(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_item(32'd4294967291, 32'd4294967291);
        send_item(32'd4294967291, 0);
        send_item(32'd4294967291, 1);
        send_item(32'd4294967291, 32'd4294967290);
        send_item(32'd4294967291, 32'hFFFFFFFF);
        send_item(32'd2047, 2);
        send_item(32'd3215031751, 2);
        send_item(32'd561, 2);
        send_item(32'd9, 32'h80000000);
        send_item(32'd65537, 32'h55555555);
        send_item(32'd65537, 32'hAAAAAAAA);
        in_ch.valid <= 0;
        drain();
        // long hold-off while the sender keeps offering items
        hold_off = 1;
        fork
            begin
                repeat (20000) @(negedge i_clk);
                hold_off = 0;
            end
            begin
                repeat (6) send_item(rand_odd(), $urandom);
                in_ch.valid <= 0;
            end
        join
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 28 : 57) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 28 : 57) : 0;
            for (int k = 0; k < 62; k++) begin
                case ($urandom_range(9))
                    0: n = $urandom;
                    1: n = primes[$urandom_range(5)];
                    2: n = spsp[$urandom_range(3)];
                    3: n = $urandom_range(8);
                    default: n = rand_odd();
                endcase
                a = ($urandom_range(7) == 0) ? n * $urandom_range(2) : $urandom;
                send_item(n, a);
            end
            in_ch.valid <= 0;
            drain();
        end
        $display("Covered %0d items: small cases, primes, pseudoprimes, random odd", sent);
        $display("candidates, under idle, stall and long hold-off patterns; %0d verdicts.",
                 verdicts);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #100000000;
        $display("TIMEOUT");
        $display("DONE: errors detected");
        $finish;
    end
endmodule
